// File: rtl/stc_pkg.sv
package stc_pkg;

  localparam int COORD_W  = 15;
  localparam int HW_W     = 10;
  localparam int OUT_W    = 16;
  localparam logic [HW_W-1:0] HW_RESET = 10'd20;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

endpackage

// File: rtl/segment_to_rectangle_corners.sv
// Segment to rectangle corners.
// Input channel: x1_i, y1_i, x2_i, y2_i are taken at a rising edge where start
// is high and busy is low. busy stays high while the item is worked on.
// Output channel: done_o is high for exactly one cycle per item; the four
// corners, seg_length_o and degenerate_o are valid in that cycle and hold
// until the next item finishes. The receiver cannot stall the block.
// Config: half_width_i is written at any edge with half_width_we_i high,
// meant only while the block is idle; reset value is 20.
// The datapath is a bit-serial shift-add multiplier (M steps, with
// M = max(COORD_BITS, 10)), a radix-4 digit-by-digit square root (one result
// bit per cycle) and two restoring dividers that produce one quotient bit per
// cycle. A new item is taken in the cycle done_o is high. Reset returns the
// block to idle, clears done_o and loads the half width register; no item is
// in flight afterwards.
module segment_to_rectangle_corners import stc_pkg::*; #(
  parameter int COORD_BITS = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] x1_i,
  input  logic [COORD_W-1:0] y1_i,
  input  logic [COORD_W-1:0] x2_i,
  input  logic [COORD_W-1:0] y2_i,
  input  logic               half_width_we_i,
  input  logic [HW_W-1:0]    half_width_i,
  output logic               done_o,
  output logic [OUT_W-1:0]   corner0_x_o,
  output logic [OUT_W-1:0]   corner0_y_o,
  output logic [OUT_W-1:0]   corner1_x_o,
  output logic [OUT_W-1:0]   corner1_y_o,
  output logic [OUT_W-1:0]   corner2_x_o,
  output logic [OUT_W-1:0]   corner2_y_o,
  output logic [OUT_W-1:0]   corner3_x_o,
  output logic [OUT_W-1:0]   corner3_y_o,
  output logic [OUT_W-1:0]   seg_length_o,
  output logic               degenerate_o
);

  localparam int CB        = COORD_BITS;
  localparam int SQ_W      = 2 * CB + 2;
  localparam int RS        = CB + 1;
  localparam int LW        = CB + 1;
  localparam int DW        = CB + HW_W;
  localparam int QB        = HW_W;
  localparam int MUL_STEPS = (CB > HW_W) ? CB : HW_W;
  localparam int MAX_STEPS = (MUL_STEPS > RS) ? MUL_STEPS : RS;
  localparam int CNT_W     = $clog2(MAX_STEPS);

  function automatic logic [OUT_W-1:0] corner_f(input logic [CB-1:0] base,
                                                input logic [HW_W-1:0] mag,
                                                input logic neg);
    logic [OUT_W-1:0] b;
    logic [OUT_W-1:0] m;
    b = OUT_W'(base);
    m = OUT_W'(mag);
    if (neg) begin
      corner_f = (b >= m) ? (b - m) : '0;
    end else begin
      corner_f = b + m;
    end
  endfunction

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [HW_W-1:0]  hw_q, hw_d;

  logic [CB-1:0]    x1_q, y1_q, x2_q, y2_q;
  logic             sx_q, sy_q;
  logic [CB-1:0]    mrx_q, mry_q;
  logic [SQ_W-1:0]  mcx_q, mcy_q;
  logic [HW_W-1:0]  hw_sh_q;
  logic [SQ_W-1:0]  sq_q, res_q, bit_q;
  logic [DW-1:0]    pox_q, poy_q, remx_q, remy_q, dsh_q;
  logic [QB-1:0]    qx_q, qy_q;
  logic [OUT_W-1:0] c0x_q, c0y_q, c1x_q, c1y_q, c2x_q, c2y_q, c3x_q, c3y_q, len_q;
  logic             degen_q;

  logic [CB-1:0]    x1m, y1m, x2m, y2m, adx, ady;
  logic             dx_neg, dy_neg;
  logic [SQ_W-1:0]  sq_sum, root_t, res_nx;
  logic             root_ge, gex, gey, degen;
  logic [QB-1:0]    omx, omy;

  // control
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    hw_d    = half_width_we_i ? half_width_i : hw_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_MUL;
          cnt_d   = '0;
        end
      end
      ST_MUL: begin
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
          state_d = ST_ROOT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ROOT: begin
        if (cnt_q == CNT_W'(RS - 1)) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(QB - 1)) begin
          state_d = ST_FIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      hw_q    <= HW_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      hw_q    <= hw_d;
    end
  end

  // datapath helpers
  always_comb begin
    x1m     = x1_i[CB-1:0];
    y1m     = y1_i[CB-1:0];
    x2m     = x2_i[CB-1:0];
    y2m     = y2_i[CB-1:0];
    dx_neg  = x2m < x1m;
    dy_neg  = y2m < y1m;
    adx     = dx_neg ? (x1m - x2m) : (x2m - x1m);
    ady     = dy_neg ? (y1m - y2m) : (y2m - y1m);
    sq_sum  = sq_q + (mrx_q[0] ? mcx_q : '0) + (mry_q[0] ? mcy_q : '0);
    root_t  = res_q + bit_q;
    root_ge = sq_q >= root_t;
    res_nx  = (res_q >> 1) + (root_ge ? bit_q : '0);
    gex     = remx_q >= dsh_q;
    gey     = remy_q >= dsh_q;
    degen   = (res_q[LW-1:0] == '0);
    omx     = degen ? '0 : qx_q;
    omy     = degen ? '0 : qy_q;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          x1_q    <= x1m;
          y1_q    <= y1m;
          x2_q    <= x2m;
          y2_q    <= y2m;
          sx_q    <= dx_neg;
          sy_q    <= dy_neg;
          mrx_q   <= adx;
          mry_q   <= ady;
          mcx_q   <= SQ_W'(adx);
          mcy_q   <= SQ_W'(ady);
          hw_sh_q <= hw_q;
          sq_q    <= '0;
          pox_q   <= '0;
          poy_q   <= '0;
        end
      end
      ST_MUL: begin
        // squares and half width products, one multiplier bit a cycle
        sq_q    <= sq_sum;
        pox_q   <= pox_q + (hw_sh_q[0] ? mcy_q[DW-1:0] : '0);
        poy_q   <= poy_q + (hw_sh_q[0] ? mcx_q[DW-1:0] : '0);
        mrx_q   <= mrx_q >> 1;
        mry_q   <= mry_q >> 1;
        mcx_q   <= mcx_q << 1;
        mcy_q   <= mcy_q << 1;
        hw_sh_q <= hw_sh_q >> 1;
        res_q   <= '0;
        bit_q   <= SQ_W'(1) << (SQ_W - 2);
      end
      ST_ROOT: begin
        if (root_ge) begin
          sq_q <= sq_q - root_t;
        end
        res_q  <= res_nx;
        bit_q  <= bit_q >> 2;
        dsh_q  <= DW'(res_nx[LW-1:0]) << (QB - 1);
        remx_q <= pox_q;
        remy_q <= poy_q;
      end
      ST_DIV: begin
        if (gex) begin
          remx_q <= remx_q - dsh_q;
        end
        if (gey) begin
          remy_q <= remy_q - dsh_q;
        end
        qx_q  <= {qx_q[QB-2:0], gex};
        qy_q  <= {qy_q[QB-2:0], gey};
        dsh_q <= dsh_q >> 1;
      end
      ST_FIN: begin
        // offset is (-dy, dx) scaled, so x moves against the sign of dy
        c0x_q   <= corner_f(x1_q, omx, !sy_q);
        c0y_q   <= corner_f(y1_q, omy, sx_q);
        c1x_q   <= corner_f(x1_q, omx, sy_q);
        c1y_q   <= corner_f(y1_q, omy, !sx_q);
        c2x_q   <= corner_f(x2_q, omx, sy_q);
        c2y_q   <= corner_f(y2_q, omy, !sx_q);
        c3x_q   <= corner_f(x2_q, omx, !sy_q);
        c3y_q   <= corner_f(y2_q, omy, sx_q);
        len_q   <= OUT_W'(res_q[LW-1:0]);
        degen_q <= degen;
      end
      default: begin
      end
    endcase
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign corner0_x_o  = c0x_q;
  assign corner0_y_o  = c0y_q;
  assign corner1_x_o  = c1x_q;
  assign corner1_y_o  = c1y_q;
  assign corner2_x_o  = c2x_q;
  assign corner2_y_o  = c2y_q;
  assign corner3_x_o  = c3x_q;
  assign corner3_y_o  = c3y_q;
  assign seg_length_o = len_q;
  assign degenerate_o = degen_q;

endmodule

// File: rtl/stc_checker.sv
module stc_checker import stc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic [OUT_W-1:0] corner0_x_o,
  input logic [OUT_W-1:0] corner0_y_o,
  input logic [OUT_W-1:0] corner1_x_o,
  input logic [OUT_W-1:0] corner1_y_o,
  input logic [OUT_W-1:0] corner2_x_o,
  input logic [OUT_W-1:0] corner2_y_o,
  input logic [OUT_W-1:0] corner3_x_o,
  input logic [OUT_W-1:0] corner3_y_o,
  input logic [OUT_W-1:0] seg_length_o,
  input logic             degenerate_o
);

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // the end of work always delivers a result
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_degen_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (degenerate_o == (seg_length_o == '0)))
    else $error("degenerate flag disagrees with length");

  a_degen_corners: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> corner0_x_o == corner1_x_o && corner0_y_o == corner1_y_o
      && corner2_x_o == corner3_x_o && corner2_y_o == corner3_y_o)
    else $error("degenerate item has a nonzero offset");

endmodule

bind segment_to_rectangle_corners stc_checker u_stc_checker (.*);

// File: tb/segment_to_rectangle_corners_tb.sv
module segment_to_rectangle_corners_tb;
  import stc_pkg::*;

  localparam int COORD_MAX      = (1 << COORD_W) - 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [HW_W-1:0]    hw_t;

  typedef struct packed {
    logic [7:0][OUT_W-1:0] corner;
    logic [OUT_W-1:0]      seg_length;
    logic                  degenerate;
  } rect_t;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             start           = 1'b0;
  logic             busy;
  coord_t           x1_i            = '0;
  coord_t           y1_i            = '0;
  coord_t           x2_i            = '0;
  coord_t           y2_i            = '0;
  logic             half_width_we_i = 1'b0;
  hw_t              half_width_i    = '0;
  logic             done_o;
  logic [OUT_W-1:0] corner0_x_o;
  logic [OUT_W-1:0] corner0_y_o;
  logic [OUT_W-1:0] corner1_x_o;
  logic [OUT_W-1:0] corner1_y_o;
  logic [OUT_W-1:0] corner2_x_o;
  logic [OUT_W-1:0] corner2_y_o;
  logic [OUT_W-1:0] corner3_x_o;
  logic [OUT_W-1:0] corner3_y_o;
  logic [OUT_W-1:0] seg_length_o;
  logic             degenerate_o;

  rect_t pending_rects[$];
  hw_t   half_width_copy = HW_RESET;
  int    send_idle_pct   = 0;
  int    errors          = 0;
  int    stall_cycles    = 0;

  segment_to_rectangle_corners i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .x1_i           (x1_i),
    .y1_i           (y1_i),
    .x2_i           (x2_i),
    .y2_i           (y2_i),
    .half_width_we_i(half_width_we_i),
    .half_width_i   (half_width_i),
    .done_o         (done_o),
    .corner0_x_o    (corner0_x_o),
    .corner0_y_o    (corner0_y_o),
    .corner1_x_o    (corner1_x_o),
    .corner1_y_o    (corner1_y_o),
    .corner2_x_o    (corner2_x_o),
    .corner2_y_o    (corner2_y_o),
    .corner3_x_o    (corner3_x_o),
    .corner3_y_o    (corner3_y_o),
    .seg_length_o   (seg_length_o),
    .degenerate_o   (degenerate_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [OUT_W-1:0] clamp_coord(longint v);
    if (v < 0) return '0;
    return v[OUT_W-1:0];
  endfunction

  function automatic rect_t predict_rectangle(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                              hw_t hw);
    rect_t  r;
    longint dx, dy, sq, root, trial, ox, oy, width;
    dx    = longint'(bx) - longint'(ay - ay) - longint'(ax);
    dy    = longint'(by) - longint'(ay);
    sq    = dx * dx + dy * dy;
    width = longint'(hw);
    root  = 0;
    for (int b = OUT_W - 1; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= sq) root = trial;
    end
    ox = 0;
    oy = 0;
    if (root != 0) begin
      ox = (-dy * width) / root;
      oy = (dx * width) / root;
    end
    r.corner[0]  = clamp_coord(longint'(ax) + ox);
    r.corner[1]  = clamp_coord(longint'(ay) + oy);
    r.corner[2]  = clamp_coord(longint'(ax) - ox);
    r.corner[3]  = clamp_coord(longint'(ay) - oy);
    r.corner[4]  = clamp_coord(longint'(bx) - ox);
    r.corner[5]  = clamp_coord(longint'(by) - oy);
    r.corner[6]  = clamp_coord(longint'(bx) + ox);
    r.corner[7]  = clamp_coord(longint'(by) + oy);
    r.seg_length = root[OUT_W-1:0];
    r.degenerate = (root == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, rect_t want, rect_t got);
    errors++;
    if (errors <= 10) begin
      $display("mismatch (%s): expected len %0d deg %0d corners %h", what, want.seg_length,
               want.degenerate, want.corner);
      $display("                got      len %0d deg %0d corners %h", got.seg_length,
               got.degenerate, got.corner);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    rect_t got;
    rect_t want;
    logic  bad;
    if (rst_ni && done_o) begin
      got.corner[0]  = corner0_x_o;
      got.corner[1]  = corner0_y_o;
      got.corner[2]  = corner1_x_o;
      got.corner[3]  = corner1_y_o;
      got.corner[4]  = corner2_x_o;
      got.corner[5]  = corner2_y_o;
      got.corner[6]  = corner3_x_o;
      got.corner[7]  = corner3_y_o;
      got.seg_length = seg_length_o;
      got.degenerate = degenerate_o;
      if (pending_rects.size() == 0) begin
        report_mismatch("result with no item pending", '0, got);
      end else begin
        want = pending_rects.pop_front();
        bad  = (got.seg_length !== want.seg_length) || (got.degenerate !== want.degenerate);
        for (int i = 0; i < 8; i++) begin
          if (got.corner[i] !== want.corner[i]) bad = 1'b1;
        end
        if (bad) report_mismatch("field", want, got);
      end
    end
  end

  // watchdog on cycles with no item and no result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    x1_i  <= ax;
    y1_i  <= ay;
    x2_i  <= bx;
    y2_i  <= by;
    do @(posedge clk_i); while (busy);
    pending_rects.push_back(predict_rectangle(ax, ay, bx, by, half_width_copy));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_rects.size() != 0 || busy);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_half_width(hw_t value);
    wait_idle();
    half_width_we_i <= 1'b1;
    half_width_i    <= value;
    @(posedge clk_i);
    half_width_we_i <= 1'b0;
    half_width_copy = value;
  endtask

  function automatic coord_t edge_coord();
    if ($urandom_range(1)) return coord_t'($urandom_range(63));
    return coord_t'(COORD_MAX - $urandom_range(63));
  endfunction

  function automatic coord_t near_coord(coord_t c);
    int d;
    int v;
    d = $urandom_range(80) - 40;
    v = int'(c) + d;
    if (v < 0 || v > COORD_MAX) v = int'(c) - d;
    return coord_t'(v);
  endfunction

  task automatic random_segment(output coord_t ax, output coord_t ay, output coord_t bx,
                                output coord_t by);
    int kind;
    kind = $urandom_range(99);
    ax   = coord_t'($urandom);
    ay   = coord_t'($urandom);
    bx   = coord_t'($urandom);
    by   = coord_t'($urandom);
    if (kind < 40) begin
    end else if (kind < 65) begin
      bx = near_coord(ax);
      by = near_coord(ay);
    end else if (kind < 80) begin
      ax = edge_coord();
      ay = edge_coord();
      bx = ($urandom_range(1)) ? edge_coord() : near_coord(ax);
      by = ($urandom_range(1)) ? edge_coord() : near_coord(ay);
    end else if (kind < 88) begin
      if ($urandom_range(1)) bx = ax;
      else by = ay;
    end else if (kind < 93) begin
      bx = ax;
      by = ay;
    end else begin
      ax = ($urandom_range(1)) ? coord_t'(COORD_MAX) : '0;
      ay = ($urandom_range(1)) ? coord_t'(COORD_MAX) : '0;
    end
  endtask

  task automatic test_reset_width();
    send_segment(0, 0, 0, 0);
    send_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_segment(0, 0, COORD_MAX, COORD_MAX);
    send_segment(COORD_MAX, 0, 0, COORD_MAX);
    send_segment(0, 0, COORD_MAX, 0);
    send_segment(COORD_MAX, COORD_MAX, 0, COORD_MAX);
    send_segment(0, 0, 0, COORD_MAX);
    send_segment(100, 100, 103, 104);
    send_segment(100, 100, 101, 101);
    send_segment(5, 5, 6, 5);
  endtask

  task automatic test_width_extremes();
    write_half_width({HW_W{1'b1}});
    send_segment(0, 0, 1, 0);
    send_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 1);
    send_segment(COORD_MAX - 1, COORD_MAX, COORD_MAX, COORD_MAX);
    send_segment(0, 0, COORD_MAX, COORD_MAX);
    send_segment(1000, 2000, 1003, 2004);
    send_segment(0, COORD_MAX, COORD_MAX, 0);
    send_segment(12345, 23456, 12345, 23456);
    send_segment(21845, 10922, 10922, 21845);
    write_half_width('0);
    send_segment(0, 0, COORD_MAX, COORD_MAX);
    send_segment(10, 10, 20, 5);
    send_segment(7, 7, 7, 7);
  endtask

  task automatic test_random_traffic(int count, int idle_pct, hw_t width);
    coord_t ax, ay, bx, by;
    write_half_width(width);
    send_idle_pct = idle_pct;
    repeat (count) begin
      random_segment(ax, ay, bx, by);
      send_segment(ax, ay, bx, by);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 34;
    test_reset_width();
    test_width_extremes();
    test_random_traffic(600, 34, hw_t'($urandom_range(1023)));
    test_random_traffic(600, 76, {HW_W{1'b1}});
    test_random_traffic(550, 0, hw_t'($urandom_range(15, 1)));
    test_random_traffic(150, 0, '0);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_rects.size() != 0) begin
      errors += pending_rects.size();
      $display("%0d items left without a result", pending_rects.size());
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/stc_pkg.sv
rtl/segment_to_rectangle_corners.sv
rtl/stc_checker.sv
tb/segment_to_rectangle_corners_tb.sv
